// ----- hdl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- hdl/pu_pkg.sv -----
// shared widths, list control type and factorial table for the unranking block
package pu_pkg;

    localparam int LEN_W  = 5;
    localparam int RANK_W = 62;

    // control beat from the sequencer to the unused-value list
    typedef struct packed {
        logic init;
        logic take;
    } pu_list_ctl_t;

    // factorial table, 0! through 20!
    function automatic logic [RANK_W-1:0] fact_of(input logic [LEN_W-1:0] idx);
        logic [RANK_W-1:0] f;
        case (idx)
            5'd0:    f = 62'd1;
            5'd1:    f = 62'd1;
            5'd2:    f = 62'd2;
            5'd3:    f = 62'd6;
            5'd4:    f = 62'd24;
            5'd5:    f = 62'd120;
            5'd6:    f = 62'd720;
            5'd7:    f = 62'd5040;
            5'd8:    f = 62'd40320;
            5'd9:    f = 62'd362880;
            5'd10:   f = 62'd3628800;
            5'd11:   f = 62'd39916800;
            5'd12:   f = 62'd479001600;
            5'd13:   f = 62'd6227020800;
            5'd14:   f = 62'd87178291200;
            5'd15:   f = 62'd1307674368000;
            5'd16:   f = 62'd20922789888000;
            5'd17:   f = 62'd355687428096000;
            5'd18:   f = 62'd6402373705728000;
            5'd19:   f = 62'd121645100408832000;
            5'd20:   f = 62'd2432902008176640000;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ----- hdl/permutation_unrank.sv -----
// top level: sequencer for lexicographic permutation unranking
//
//  channel   signals                          handshake
//  command   start, busy, length, rank        taken when start high and busy low
//  result    result_valid, value, last, error valid strobe per beat, no backpressure
//
// an accepted command first has its length and range checked, then for each of
// the n values runs a restoring division for IDX_W quotient bits on the shared
// compare/subtract unit, then a pick step; a rejected command goes back to idle
// after the check.
// each beat is registered and appears in the cycle after the cycle that forms it.
// rst_n clears the sequencer and the result strobe at once; the list and payload are not reset.
// the receiver cannot stall, so the block never waits on the result side.
`include "assert_macros.svh"
module permutation_unrank #(
    parameter int MAX_LEN = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [pu_pkg::LEN_W-1:0]    length,
    input  logic [pu_pkg::RANK_W-1:0]   rank,
    output logic                        result_valid,
    output logic [pu_pkg::LEN_W-1:0]    value,
    output logic                        last,
    output logic                        error
);

    localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int BIT_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;
    localparam int WIDE_W = pu_pkg::RANK_W + IDX_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_PICK  = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [pu_pkg::LEN_W-1:0]   n_reg, n_next;
    logic [pu_pkg::LEN_W-1:0]   m_reg, m_next;
    logic [pu_pkg::RANK_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]           digit_reg, digit_next;
    logic [BIT_W-1:0]           bit_reg, bit_next;
    logic                       result_valid_reg, result_valid_next;
    logic [pu_pkg::LEN_W-1:0]   value_reg, value_next;
    logic                       last_reg, last_next;
    logic                       error_reg, error_next;

    logic [WIDE_W-1:0]          op_a;
    logic [WIDE_W-1:0]          op_b;
    logic                       op_ge;
    logic [WIDE_W-1:0]          op_diff;
    logic                       len_bad;
    pu_pkg::pu_list_ctl_t       list_ctl;
    logic [pu_pkg::LEN_W-1:0]   list_pick;

    assign len_bad = (n_reg == '0) || (n_reg > pu_pkg::LEN_W'(MAX_LEN));

    // operand select: n! for the range check, (m-1)! shifted for a division step
    always_comb
    begin
        op_a = WIDE_W'(k_reg);
        case (state_reg)
            ST_CHECK: op_b = WIDE_W'(pu_pkg::fact_of(n_reg));
            ST_DIV:   op_b = WIDE_W'(pu_pkg::fact_of(pu_pkg::LEN_W'(m_reg - 1'b1)))
                             << bit_reg;
            default:  op_b = '0;
        endcase
    end

    pu_cmpsub #(
        .W (WIDE_W)
    ) u_cmpsub (
        .a    (op_a),
        .b    (op_b),
        .ge   (op_ge),
        .diff (op_diff)
    );

    pu_list #(
        .MAX_LEN (MAX_LEN),
        .IDX_W   (IDX_W)
    ) u_list (
        .clk  (clk),
        .ctl  (list_ctl),
        .idx  (digit_reg),
        .pick (list_pick)
    );

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        n_next            = n_reg;
        m_next            = m_reg;
        k_next            = k_reg;
        digit_next        = digit_reg;
        bit_next          = bit_reg;
        result_valid_next = 1'b0;
        value_next        = value_reg;
        last_next         = last_reg;
        error_next        = error_reg;
        list_ctl.init     = 1'b0;
        list_ctl.take     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = length;
                    m_next     = length;
                    k_next     = rank;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (len_bad || op_ge)
                begin
                    result_valid_next = 1'b1;
                    value_next        = '0;
                    last_next         = 1'b1;
                    error_next        = 1'b1;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    list_ctl.init = 1'b1;
                    digit_next    = '0;
                    bit_next      = BIT_W'(IDX_W - 1);
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                if (op_ge)
                begin
                    k_next             = op_diff[pu_pkg::RANK_W-1:0];
                    digit_next[bit_reg] = 1'b1;
                end
                if (bit_reg == '0)
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_PICK:
            begin
                list_ctl.take     = 1'b1;
                result_valid_next = 1'b1;
                value_next        = list_pick;
                last_next         = (m_reg == pu_pkg::LEN_W'(1));
                error_next        = 1'b0;
                m_next            = m_reg - 1'b1;
                digit_next        = '0;
                bit_next          = BIT_W'(IDX_W - 1);
                if (m_reg == pu_pkg::LEN_W'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        m_reg     <= m_next;
        k_reg     <= k_next;
        digit_reg <= digit_next;
        bit_reg   <= bit_next;
        value_reg <= value_next;
        last_reg  <= last_next;
        error_reg <= error_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign last         = last_reg;
    assign error        = error_reg;

    // error beat is a lone last beat with value zero
    `ASSERT_PROP(a_err_beat, clk, rst_n, (result_valid && error) |-> (last && value == '0))
    // a good beat carries a nonzero value
    `ASSERT_PROP(a_good_value, clk, rst_n, (result_valid && !error) |-> (value != '0))
    // after the last beat the block is free
    `ASSERT_PROP(a_last_idle, clk, rst_n, (result_valid && last) |-> !busy)
    // a bad length is rejected right after the check cycle
    `ASSERT_PROP(a_bad_len, clk, rst_n,
        (start && !busy && (length == '0 || length > pu_pkg::LEN_W'(MAX_LEN)))
        |=> ##1 (result_valid && error))
    // no beat in the pick state when it was entered from the division state
    `ASSERT_NEVER(a_div_quiet, clk, rst_n,
        result_valid && (state_reg == ST_PICK) && $past(state_reg == ST_DIV))

endmodule

// ----- hdl/pu_cmpsub.sv -----
// shared compare and subtract unit for range check and restoring division
module pu_cmpsub #(
    parameter int W = 67
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         ge,
    output logic [W-1:0] diff
);

    logic [W:0] sub;

    // one wide subtract, borrow gives the compare
    assign sub  = {1'b0, a} - {1'b0, b};
    assign ge   = ~sub[W];
    assign diff = sub[W-1:0];

endmodule

// ----- hdl/pu_list.sv -----
// sorted list of unused values with indexed pick and removal
module pu_list #(
    parameter int MAX_LEN = 20,
    parameter int IDX_W   = 5
) (
    input  logic                      clk,
    input  pu_pkg::pu_list_ctl_t      ctl,
    input  logic [IDX_W-1:0]          idx,
    output logic [pu_pkg::LEN_W-1:0]  pick
);

    logic [pu_pkg::LEN_W-1:0] list_reg [MAX_LEN];

    // read the entry at the digit
    always_comb
    begin
        pick = '0;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (idx == IDX_W'(i))
            begin
                pick = list_reg[i];
            end
        end
    end

    // fill with 1..MAX_LEN, or close the gap left by the taken entry
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (ctl.init)
            begin
                list_reg[i] <= pu_pkg::LEN_W'(i + 1);
            end
            else if (ctl.take && (IDX_W'(i) >= idx))
            begin
                if (i == MAX_LEN - 1)
                begin
                    list_reg[i] <= '0;
                end
                else
                begin
                    list_reg[i] <= list_reg[i + 1];
                end
            end
        end
    end

endmodule
